// File: hw/rtl/idq_pkg.sv
// Shared types, codes and sizes for the indexed double-ended queue.
// No dependencies; every other file in hw/rtl except idq_ram imports this package.
package idq_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int AW         = $clog2(DEPTH);
  localparam int CW         = AW + 1;

  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  // request modes as they arrive on the port
  localparam logic [3:0] MODE_PUSH_FRONT = 4'd0;
  localparam logic [3:0] MODE_PUSH_BACK  = 4'd1;
  localparam logic [3:0] MODE_POP_FRONT  = 4'd2;
  localparam logic [3:0] MODE_POP_BACK   = 4'd3;
  localparam logic [3:0] MODE_INSERT     = 4'd4;
  localparam logic [3:0] MODE_REMOVE     = 4'd5;
  localparam logic [3:0] MODE_FIND       = 4'd6;
  localparam logic [3:0] MODE_SWAP       = 4'd7;
  localparam logic [3:0] MODE_REVERSE    = 4'd8;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [3:0]  mode;
    logic [6:0]  position;
    logic [5:0]  second_position;
    logic [31:0] value_in;
  } req_t;

  typedef struct packed {
    logic [31:0] value_out;
    logic [6:0]  element_count;
    logic [5:0]  found_position;
    logic [2:0]  status;
  } rsp_t;

  typedef enum logic [3:0] {
    OP_PUSH_FRONT = 4'd0,
    OP_PUSH_BACK  = 4'd1,
    OP_POP_FRONT  = 4'd2,
    OP_POP_BACK   = 4'd3,
    OP_INSERT     = 4'd4,
    OP_REMOVE     = 4'd5,
    OP_FIND       = 4'd6,
    OP_SWAP       = 4'd7,
    OP_REVERSE    = 4'd8,
    OP_NOP        = 4'd9
  } op_t;

  // classified request handed from the front part to the back part
  typedef struct packed {
    op_t                   op;
    logic [CW-1:0]         position;
    logic [AW-1:0]         second_position;
    logic [DATA_WIDTH-1:0] value;
  } cmd_t;

  // physical slot of the k-th occupied slot
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base, input logic [CW-1:0] k);
    slot_of = base + k[AW-1:0];
  endfunction

endpackage

// File: hw/rtl/indexed_double_ended_queue_unit.sv
// Top level of the indexed double-ended queue: front classifier, back
// sequencer with word store. Depends on idq_pkg, idq_front, idq_back.
//
//  channel  | signals                 | payload
//  ---------+-------------------------+-----------------------------------
//  request  | req_valid / req_stall   | req  (mode, positions, value_in)
//  response | rsp_valid / rsp_stall   | rsp  (value_out, count, found, status)
//
// Insert and remove in the middle move one word per cycle through the single
// store port; find reads one word per cycle.
// The back sequencer handles one transaction at a time.
// Reset (rst, synchronous) empties the queue and clears the direction flag;
// the store itself is not cleared.
// Two request transactions can wait in the front queue, and a finished
// response sits in its own register, so the back starts the next request
// while a response is stalled and only waits at its end for the register.
module indexed_double_ended_queue_unit import idq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  // front: accept and classify
  idq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // back: execute against the store, drive responses
  idq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// File: hw/rtl/idq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module idq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/idq_front.sv
// Front part: accepts request transactions, classifies the mode and holds
// them in a two-entry queue for the back part. Depends on idq_pkg.
module idq_front import idq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic cmd_valid,
  output cmd_t cmd,
  input  logic cmd_take
);

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  cmd_t       decoded;

  always_comb begin
    decoded.position        = CW'(req.position);
    decoded.second_position = AW'(req.second_position);
    decoded.value           = DATA_WIDTH'(req.value_in);
    case (req.mode)
      MODE_PUSH_FRONT: decoded.op = OP_PUSH_FRONT;
      MODE_PUSH_BACK:  decoded.op = OP_PUSH_BACK;
      MODE_POP_FRONT:  decoded.op = OP_POP_FRONT;
      MODE_POP_BACK:   decoded.op = OP_POP_BACK;
      MODE_INSERT:     decoded.op = OP_INSERT;
      MODE_REMOVE:     decoded.op = OP_REMOVE;
      MODE_FIND:       decoded.op = OP_FIND;
      MODE_SWAP:       decoded.op = OP_SWAP;
      MODE_REVERSE:    decoded.op = OP_REVERSE;
      default:         decoded.op = OP_NOP;
    endcase
  end

  assign req_stall = (fill == 2'd2);
  assign push      = req_valid && !req_stall;
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= decoded;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_take) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, cmd_take})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: hw/rtl/idq_back.sv
// Back part: owns the word store, pointers and flags, runs one request at
// a time through a sequencer and holds the response register.
// Depends on idq_pkg and idq_ram.
module idq_back import idq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_take,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_RV_CAP = 9'b000000010,
    S_MOVE   = 9'b000000100,
    S_INS_W  = 9'b000001000,
    S_FIND   = 9'b000010000,
    S_SW_B   = 9'b000100000,
    S_SW_WA  = 9'b001000000,
    S_SW_WB  = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t                state;
  logic [AW-1:0]         front_ptr;
  logic [CW-1:0]         count;
  logic                  rev;
  op_t                   op;
  logic [CW-1:0]         qk;
  logic [DATA_WIDTH-1:0] vin;
  logic [AW-1:0]         addr_a;
  logic [AW-1:0]         addr_b;
  logic [DATA_WIDTH-1:0] tmp;
  logic [CW-1:0]         rsrc;
  logic [CW-1:0]         wdst;
  logic [CW-1:0]         rleft;
  logic [CW-1:0]         wleft;
  logic                  rd_pend;
  logic [CW-1:0]         fcmp;
  logic [DATA_WIDTH-1:0] res_value;
  logic [AW-1:0]         res_found;
  logic [2:0]            res_status;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] rdata;

  logic [CW-1:0] ins_pos;
  logic [CW-1:0] ins_q;
  logic [CW-1:0] rem_pos;
  logic [CW-1:0] rem_q;
  logic [CW-1:0] pos2;
  logic [AW-1:0] swap_a;
  logic [AW-1:0] swap_b;
  logic [CW-1:0] find_phys;
  logic          ins_direct;
  logic          move_down;

  idq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  assign cmd_take = (state == S_IDLE) && cmd_valid;

  // request classification against the current count and direction
  always_comb begin
    case (cmd.op)
      OP_PUSH_FRONT: ins_pos = '0;
      OP_PUSH_BACK:  ins_pos = count;
      default:       ins_pos = cmd.position;
    endcase
    ins_q = rev ? (count - ins_pos) : ins_pos;
    case (cmd.op)
      OP_POP_FRONT: rem_pos = '0;
      OP_POP_BACK:  rem_pos = count - 1'b1;
      default:      rem_pos = cmd.position;
    endcase
    rem_q     = rev ? (count - 1'b1 - rem_pos) : rem_pos;
    pos2      = CW'(cmd.second_position);
    swap_a    = slot_of(front_ptr, rev ? (count - 1'b1 - cmd.position) : cmd.position);
    swap_b    = slot_of(front_ptr, rev ? (count - 1'b1 - pos2) : pos2);
    find_phys = rev ? (count - 1'b1 - rsrc) : rsrc;
    ins_direct = cmd_valid && (ins_pos <= count) && (count != DEPTH_C) && (ins_q == '0)
                 && (cmd.op == OP_PUSH_FRONT || cmd.op == OP_PUSH_BACK
                     || cmd.op == OP_INSERT);
    move_down = (op == OP_PUSH_FRONT || op == OP_PUSH_BACK || op == OP_INSERT);
  end

  // store port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_of(front_ptr, wdst);
    ram_wdata = rdata;
    ram_raddr = slot_of(front_ptr, rsrc);
    case (state)
      S_IDLE: begin
        ram_raddr = (cmd.op == OP_SWAP) ? swap_a : slot_of(front_ptr, rem_q);
        if (ins_direct) begin
          ram_we    = 1'b1;
          ram_waddr = front_ptr - 1'b1;
          ram_wdata = cmd.value;
        end
      end
      S_MOVE: ram_we = rd_pend;
      S_INS_W: begin
        ram_we    = 1'b1;
        ram_waddr = slot_of(front_ptr, qk);
        ram_wdata = vin;
      end
      S_FIND: ram_raddr = slot_of(front_ptr, find_phys);
      S_SW_B: ram_raddr = addr_b;
      S_SW_WA: begin
        ram_we    = 1'b1;
        ram_waddr = addr_a;
      end
      S_SW_WB: begin
        ram_we    = 1'b1;
        ram_waddr = addr_b;
        ram_wdata = tmp;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front_ptr <= '0;
      count     <= '0;
      rev       <= 1'b0;
      rsp_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            op         <= cmd.op;
            vin        <= cmd.value;
            res_value  <= '0;
            res_found  <= '0;
            res_status <= ST_OK;
            rd_pend    <= 1'b0;
            state      <= S_DONE;
            case (cmd.op)
              OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
                if (ins_pos > count) begin
                  res_status <= ST_RANGE;
                end else if (count == DEPTH_C) begin
                  res_status <= ST_FULL;
                end else if (ins_q == '0) begin
                  front_ptr <= front_ptr - 1'b1;
                  count     <= count + 1'b1;
                end else begin
                  qk    <= ins_q;
                  rsrc  <= count - 1'b1;
                  wdst  <= count;
                  rleft <= count - ins_q;
                  wleft <= count - ins_q;
                  state <= (ins_q == count) ? S_INS_W : S_MOVE;
                end
              end
              OP_POP_FRONT, OP_POP_BACK, OP_REMOVE: begin
                if (count == '0) begin
                  res_status <= ST_EMPTY;
                end else if (rem_pos >= count) begin
                  res_status <= ST_RANGE;
                end else begin
                  qk    <= rem_q;
                  state <= S_RV_CAP;
                end
              end
              OP_FIND: begin
                res_status <= ST_NOTFOUND;
                if (count != '0) begin
                  rsrc  <= '0;
                  rleft <= count;
                  state <= S_FIND;
                end
              end
              OP_SWAP: begin
                if (cmd.position >= count || pos2 >= count) begin
                  res_status <= ST_RANGE;
                end else begin
                  addr_a <= swap_a;
                  addr_b <= swap_b;
                  state  <= S_SW_B;
                end
              end
              OP_REVERSE: rev <= ~rev;
              default: ;
            endcase
          end
        end
        S_RV_CAP: begin
          res_value <= rdata;
          if (qk == '0) begin
            front_ptr <= front_ptr + 1'b1;
            count     <= count - 1'b1;
            state     <= S_DONE;
          end else if (qk == count - 1'b1) begin
            count <= count - 1'b1;
            state <= S_DONE;
          end else begin
            rsrc  <= qk + 1'b1;
            wdst  <= qk;
            rleft <= count - 1'b1 - qk;
            wleft <= count - 1'b1 - qk;
            state <= S_MOVE;
          end
        end
        S_MOVE: begin
          // read one slot ahead, write the word read last cycle
          if (rleft != '0) begin
            rsrc    <= move_down ? (rsrc - 1'b1) : (rsrc + 1'b1);
            rleft   <= rleft - 1'b1;
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_pend) begin
            wdst  <= move_down ? (wdst - 1'b1) : (wdst + 1'b1);
            wleft <= wleft - 1'b1;
            if (wleft == CW'(1)) begin
              rd_pend <= 1'b0;
              if (move_down) begin
                state <= S_INS_W;
              end else begin
                count <= count - 1'b1;
                state <= S_DONE;
              end
            end
          end
        end
        S_INS_W: begin
          count <= count + 1'b1;
          state <= S_DONE;
        end
        S_FIND: begin
          if (rleft != '0) begin
            rsrc    <= rsrc + 1'b1;
            rleft   <= rleft - 1'b1;
            fcmp    <= rsrc;
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_pend && rdata == vin) begin
            res_found  <= fcmp[AW-1:0];
            res_status <= ST_OK;
            rd_pend    <= 1'b0;
            state      <= S_DONE;
          end else if (!rd_pend && rleft == '0) begin
            state <= S_DONE;
          end
        end
        S_SW_B: begin
          tmp   <= rdata;
          state <= S_SW_WA;
        end
        S_SW_WA: state <= S_SW_WB;
        S_SW_WB: state <= S_DONE;
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp.value_out      <= 32'(res_value);
            rsp.element_count  <= 7'(count);
            rsp.found_position <= 6'(res_found);
            rsp.status         <= res_status;
            rsp_valid          <= 1'b1;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
